// File: rtl/shift_jis_to_jis_byte_decoder_defines.svh
// Assertion macros used by the Shift-JIS decoder RTL (sjd_back).
// Included by modules that carry concurrent checks; needs no other file.
`ifndef SHIFT_JIS_TO_JIS_BYTE_DECODER_DEFINES_SVH
`define SHIFT_JIS_TO_JIS_BYTE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SJD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SJD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sjd_pkg.sv
// Types and constants for the Shift-JIS to JIS decoder.
// Used by sjd_front, sjd_queue, sjd_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sjd_pkg;

    localparam logic [7:0] LEAD_A_LO   = 8'h81;
    localparam logic [7:0] LEAD_A_HI   = 8'h9F;
    localparam logic [7:0] LEAD_B_LO   = 8'hE0;
    localparam logic [7:0] LEAD_B_HI   = 8'hEF;
    localparam logic [7:0] LEAD_A_OFS  = 8'd112;
    localparam logic [7:0] LEAD_B_OFS  = 8'd176;
    localparam logic [7:0] TRAIL_HI_LO = 8'h9F;
    localparam logic [7:0] TRAIL_HI_OFS = 8'd126;
    localparam logic [7:0] TRAIL_LO_LO = 8'h40;
    localparam logic [7:0] TRAIL_LO_OFS = 8'd31;
    localparam logic [7:0] GAP_BYTE    = 8'h80;
    localparam logic [7:0] ERR_CODE    = 8'h7F;
    localparam logic [7:0] BOX_ROW_MASK = 8'hFC;
    localparam logic [7:0] BOX_ROW_BASE = 8'h28;

    localparam int unsigned RES_WIDTH   = 19;
    localparam int unsigned TDATA_WIDTH = 24;

    typedef enum logic [1:0] {
        TRAIL_HIGH = 2'd0,  // keeps the row
        TRAIL_LOW  = 2'd1,  // steps the row back by one
        TRAIL_ERR  = 2'd2   // illegal second byte
    } t_trail;

    // Byte after classification; fields valid for either role of the byte.
    typedef struct packed {
        logic [7:0] raw;
        logic       is_lead;
        logic [7:0] lead_row;
        t_trail     trail;
        logic [7:0] trail_col;
    } t_cls;

endpackage

`default_nettype wire

// File: rtl/sjd_front.sv
// Front stage: registers each incoming byte with its lead/trail classification.
// Depends on sjd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjd_front
    import sjd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_cls            o_cls
);

    logic r_valid;
    t_cls r_cls;
    t_cls n_cls;
    logic lead_a;
    logic lead_b;

    always_comb begin
        lead_a = (i_byte >= LEAD_A_LO) && (i_byte <= LEAD_A_HI);
        lead_b = (i_byte >= LEAD_B_LO) && (i_byte <= LEAD_B_HI);
        n_cls.raw     = i_byte;
        n_cls.is_lead = lead_a || lead_b;
        // Provisional row is twice the offset byte, kept to eight bits
        if (lead_a) begin
            n_cls.lead_row = 8'((i_byte - LEAD_A_OFS) << 1);
        end else begin
            n_cls.lead_row = 8'((i_byte - LEAD_B_OFS) << 1);
        end
        if (i_byte >= TRAIL_HI_LO) begin
            n_cls.trail     = TRAIL_HIGH;
            n_cls.trail_col = i_byte - TRAIL_HI_OFS;
        end else if ((i_byte >= TRAIL_LO_LO) && (i_byte != ERR_CODE)) begin
            n_cls.trail = TRAIL_LOW;
            // one more off above 0x7F to close the hole left by 0x7F
            n_cls.trail_col = i_byte - TRAIL_LO_OFS - {7'd0, (i_byte >= GAP_BYTE)};
        end else begin
            n_cls.trail     = TRAIL_ERR;
            n_cls.trail_col = ERR_CODE;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_cls   = r_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cls <= n_cls;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sjd_queue.sv
// Two-entry queue of classified words between the front and back stages.
// Depends on sjd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sjd_queue
    import sjd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cls i_cls,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cls      o_cls
);

    localparam int unsigned DEPTH = 2;

    t_cls        r_mem [DEPTH];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;

    assign o_ready = (r_count != 2'(DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign o_cls   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !push) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

endmodule

`default_nettype wire

// File: rtl/sjd_back.sv
// Back stage: holds the pending-lead state and row, forms each result word
// into an output register. Depends on sjd_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "shift_jis_to_jis_byte_decoder_defines.svh"

module sjd_back
    import sjd_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire t_cls                   i_cls,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [TDATA_WIDTH-1:0]      o_data
);

    logic                  r_pend;
    logic [7:0]            r_row;
    logic                  r_valid;
    logic [RES_WIDTH-1:0]  r_res;

    logic                  take;
    logic                  n_pend;
    logic [7:0]            n_row;
    logic [7:0]            n_second;
    logic                  n_wide;
    logic                  n_done;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        n_pend   = 1'b0;
        n_row    = r_row;
        n_second = 8'd0;
        n_wide   = 1'b0;
        n_done   = 1'b1;
        if (!r_pend) begin
            if (i_cls.is_lead) begin
                n_pend = 1'b1;
                n_row  = i_cls.lead_row;
                n_wide = 1'b1;
                n_done = 1'b0;
            end else begin
                n_row = i_cls.raw;
            end
        end else begin
            n_second = i_cls.trail_col;
            case (i_cls.trail)
                TRAIL_HIGH: n_row = r_row;
                TRAIL_LOW:  n_row = r_row - 8'd1;
                TRAIL_ERR:  n_row = ERR_CODE;
                default:    n_row = ERR_CODE;
            endcase
            // box-drawing rows are single cell
            n_wide = ((n_row & BOX_ROW_MASK) != BOX_ROW_BASE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_row   <= 8'd0;
            r_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_pend <= n_pend;
                r_row  <= n_row;
            end
        end
        if (take) begin
            r_res <= {n_pend, n_wide, n_second, n_row, n_done};
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {(TDATA_WIDTH - RES_WIDTH)'(0), r_res};

    `SJD_ASSERT_NEXT(a_lead_sets_pend, i_clk, i_rst_n, take && i_cls.is_lead && !r_pend, r_pend, "lead byte did not arm pending state")
    `SJD_ASSERT_NEXT(a_trail_clears_pend, i_clk, i_rst_n, take && r_pend, !r_pend, "trail byte left pending state set")
    `SJD_ASSERT_NOW(a_await_matches_state, i_clk, i_rst_n, r_valid && r_res[RES_WIDTH-1], r_pend && !r_res[0], "awaiting result without pending lead")

endmodule

`default_nettype wire

// File: rtl/shift_jis_to_jis_byte_decoder.sv
// Shift-JIS byte stream to JIS X 0208 row/column decoder, top level.
// Instantiates sjd_front, sjd_queue and sjd_back; depends on sjd_pkg.
//
// Takes one Shift-JIS byte per word and returns one result word per byte, at a
// sustained rate of one byte per clock while neither side stalls. A result
// passes through the classify register and the two-entry queue before it is
// written to the output register. The rate is set by the back stage's update
// of the pending-lead flag and JIS row, which every byte must pass in order.
// Either side may stall without stopping the other until the queue fills.
// Output tdata from bit 0 up: complete, first_code[7:0], second_code[7:0],
// double_wide, awaiting_second, five zero bits.
`timescale 1ns / 1ps
`default_nettype none

module shift_jis_to_jis_byte_decoder
    import sjd_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire logic [7:0]              i_s_axis_tdata,  // byte_in[7:0]
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    // complete, first_code[7:0], second_code[7:0], double_wide, awaiting_second, pad
    output logic [TDATA_WIDTH-1:0]       o_m_axis_tdata
);

    logic f_valid;
    logic f_ready;
    t_cls f_cls;
    logic q_valid;
    logic q_ready;
    t_cls q_cls;

    sjd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_byte  (i_s_axis_tdata),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cls   (f_cls)
    );

    sjd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cls   (f_cls),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cls   (q_cls)
    );

    sjd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cls   (q_cls),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: tb/sjd_decode_checker.sv
// Watches both streams of the Shift-JIS decoder, predicts each result word and compares.
// Needs sjd_pkg for the byte ranges, offsets and the trail-byte classes.
`timescale 1ns / 1ps

module sjd_decode_checker
    import sjd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_word,   // complete, first_code, second_code, double_wide, awaiting_second
    output int          o_outstanding,
    output int          o_fail_count
);

    typedef struct packed {
        logic       complete;
        logic [7:0] first_code;
        logic [7:0] second_code;
        logic       double_wide;
        logic       awaiting_second;
    } t_code;

    // decoder state mirror
    logic       lead_held;
    logic       wide_q;
    logic [7:0] row_q;
    logic [7:0] col_q;

    t_code decoded_queue[$];

    function automatic t_code decode_byte(input logic [7:0] c);
        t_code  r;
        t_trail kind;
        logic   done;
        done = 1'b1;
        if (!lead_held) begin
            wide_q = 1'b0;
            if (c >= LEAD_A_LO && c <= LEAD_A_HI) begin
                row_q     = (c - LEAD_A_OFS) * 8'd2;
                wide_q    = 1'b1;
                lead_held = 1'b1;
                done      = 1'b0;
            end else if (c >= LEAD_B_LO && c <= LEAD_B_HI) begin
                row_q     = (c - LEAD_B_OFS) * 8'd2;
                wide_q    = 1'b1;
                lead_held = 1'b1;
                done      = 1'b0;
            end else begin
                row_q = c;
                col_q = 8'h00;
            end
        end else begin
            if (c >= TRAIL_HI_LO)
                kind = TRAIL_HIGH;
            else if (c >= TRAIL_LO_LO && c != ERR_CODE)
                kind = TRAIL_LOW;
            else
                kind = TRAIL_ERR;
            case (kind)
                TRAIL_HIGH: begin
                    col_q = c - TRAIL_HI_OFS;
                end
                TRAIL_LOW: begin
                    row_q = row_q - 8'd1;
                    col_q = c - TRAIL_LO_OFS;
                    if (c >= GAP_BYTE)
                        col_q = col_q - 8'd1;   // skip the hole at 0x7F
                end
                default: begin
                    row_q = ERR_CODE;
                    col_q = ERR_CODE;
                end
            endcase
            // box-drawing rows are single-wide
            if ((row_q & BOX_ROW_MASK) == BOX_ROW_BASE)
                wide_q = 1'b0;
            lead_held = 1'b0;
        end
        r.complete        = done;
        r.first_code      = row_q;
        r.second_code     = done ? col_q : 8'h00;
        r.double_wide     = wide_q;
        r.awaiting_second = lead_held;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_code want;
        t_code got;
        if (!i_rst_n) begin
            lead_held    = 1'b0;
            wide_q       = 1'b0;
            row_q        = 8'h00;
            col_q        = 8'h00;
            o_fail_count = 0;
            decoded_queue.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                decoded_queue.push_back(decode_byte(i_in_byte));
            if (i_out_valid && i_out_ready) begin
                got.complete        = i_out_word[0];
                got.first_code      = i_out_word[8:1];
                got.second_code     = i_out_word[16:9];
                got.double_wide     = i_out_word[17];
                got.awaiting_second = i_out_word[18];
                if (decoded_queue.size() == 0) begin
                    $error("result word %h with none outstanding", i_out_word);
                    o_fail_count++;
                end else begin
                    want = decoded_queue.pop_front();
                    if (got.complete !== want.complete) begin
                        $error("complete: expected %0d, actual %0d", want.complete, got.complete);
                        o_fail_count++;
                    end
                    if (got.first_code !== want.first_code) begin
                        $error("first_code: expected %h, actual %h",
                               want.first_code, got.first_code);
                        o_fail_count++;
                    end
                    if (got.second_code !== want.second_code) begin
                        $error("second_code: expected %h, actual %h",
                               want.second_code, got.second_code);
                        o_fail_count++;
                    end
                    if (got.double_wide !== want.double_wide) begin
                        $error("double_wide: expected %0d, actual %0d",
                               want.double_wide, got.double_wide);
                        o_fail_count++;
                    end
                    if (got.awaiting_second !== want.awaiting_second) begin
                        $error("awaiting_second: expected %0d, actual %0d",
                               want.awaiting_second, got.awaiting_second);
                        o_fail_count++;
                    end
                end
            end
        end
        o_outstanding = decoded_queue.size();
    end

endmodule

// File: tb/tb.sv
// Top of the Shift-JIS decoder bench: clock, reset, byte stimulus, sink stalls and verdict.
// Instantiates shift_jis_to_jis_byte_decoder and sjd_decode_checker; uses sjd_pkg.
`timescale 1ns / 1ps

module tb;
    import sjd_pkg::*;

    localparam int unsigned RANDOM_BYTES = 1500;
    localparam int unsigned QUIET_AFTER  = 1300;
    localparam int unsigned CYCLE_LIMIT  = 200000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [7:0]             s_tdata = 8'h00;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_WIDTH-1:0] m_tdata;

    int          outstanding;
    int          fail_count;
    int unsigned cycles = 0;
    int unsigned sent = 0;
    logic        quiet = 1'b0;

    always #5 clk = ~clk;

    shift_jis_to_jis_byte_decoder u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    sjd_decode_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_tvalid),
        .i_in_ready    (s_tready),
        .i_in_byte     (s_tdata),
        .i_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .i_out_word    (m_tdata),
        .o_outstanding (outstanding),
        .o_fail_count  (fail_count)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        gap = 0;
        if (!quiet && ((sent / 64) % 2 == 1) && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        sent++;
        if (sent >= QUIET_AFTER)
            quiet = 1'b1;
        @(negedge clk);
    endtask

    function automatic logic [7:0] any_lead();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(LEAD_A_LO, LEAD_A_HI));
        return 8'($urandom_range(LEAD_B_LO, LEAD_B_HI));
    endfunction

    // sink: stall bursts in alternating stretches, one long hold-off to back up the input
    initial begin
        int unsigned ticks;
        int unsigned burst;
        ticks = 0;
        wait (rst_n);
        forever begin
            @(negedge clk);
            ticks++;
            if (ticks == 400) begin
                m_tready <= 1'b0;
                repeat (200) @(negedge clk);
                m_tready <= 1'b1;
            end else if (!quiet && ((ticks / 128) % 2 == 0) && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (burst) @(negedge clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] directed[25];
        logic [7:0] trail;
        directed = '{
            8'h00, 8'h7F, 8'h80, 8'hA0, 8'hDF, 8'hF0, 8'hFF,
            8'h81, 8'h40,     // lowest lead, lowest low trail
            8'h9F, 8'hFF,     // top of first lead range, high trail
            8'hE0, 8'h9F,     // second lead range, first high trail
            8'hEF, 8'h9E,     // top lead, last low trail past the gap
            8'h88, 8'h7F,     // hole in the trail range
            8'h90, 8'h3F,     // trail below range
            8'h84, 8'hA0,     // box-drawing row kept
            8'h85, 8'h80,     // row steps back, stays in box-drawing rows
            8'h81, 8'h81      // lead byte value used as trail
        };
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[k])
            push_byte(directed[k]);

        while (sent < RANDOM_BYTES + 25) begin
            if ($urandom_range(0, 9) < 6) begin
                push_byte(any_lead());
                if ($urandom_range(0, 7) == 0) begin
                    trail = 8'($urandom_range(0, 255));
                end else begin
                    trail = 8'($urandom_range(TRAIL_LO_LO, 8'hFC));
                    if (trail == ERR_CODE)
                        trail = GAP_BYTE;
                end
                push_byte(trail);
            end else begin
                push_byte(8'($urandom_range(0, 255)));
            end
        end
        s_tvalid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sjd_pkg.sv
rtl/sjd_front.sv
rtl/sjd_queue.sv
rtl/sjd_back.sv
rtl/shift_jis_to_jis_byte_decoder.sv
tb/sjd_decode_checker.sv
tb/tb.sv
